// ===== hdl/aisdec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the de-armor function of the AIS sentence decoder.
package aisdec_pkg;

  localparam int MAX_SYMBOLS_DEF = 64;

  localparam logic [7:0] CH_COMMA      = 8'd44;
  localparam logic [2:0] PAYLOAD_FIELD = 3'd5;
  localparam logic [2:0] COMMA_SAT     = 3'd7;

  localparam int HDR_SYMS      = 10;
  localparam int FIRST_PAY_SYM = 9;
  localparam int MAX_WORDS     = 11;
  localparam int WORD_BITS     = 32;
  localparam int BUF_W         = 38;
  localparam int FILL_W        = 6;
  localparam int WCNT_W        = 4;

  // symbols needed before a header field reads nonzero
  localparam int MIN_SYM_TYPE   = 1;
  localparam int MIN_SYM_REPEAT = 2;
  localparam int MIN_SYM_MMSI   = 7;
  localparam int MIN_SYM_SPARE  = 7;
  localparam int MIN_SYM_AREA   = 9;
  localparam int MIN_SYM_FUNC   = 10;

  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_WORD = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_HDR,
    ST_RD,
    ST_APP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic hdr_load;
    logic rd;
    logic app;
    logic wload;
    logic wlast;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic hdr_last;
    logic fill_ge32;
    logic fill_eq32;
    logic more;
    logic wcnt_max;
    logic out_free;
  } stat_t;

  function automatic logic [5:0] dearmor(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd40;
    if (c inside {[8'd48:8'd87]}) begin
      d = c - 8'd48;
    end else if (c inside {[8'd97:8'd119]}) begin
      d = c - 8'd56;
    end
    return d[5:0];
  endfunction

endpackage

// ===== hdl/aisdec_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the AIS sentence decoder.
module aisdec_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_end_of_sentence,
  output logic               in_stall,
  input  aisdec_pkg::stat_t  st,
  output aisdec_pkg::cmd_t   cmd
);

  aisdec_pkg::state_t state_r, state_nxt;
  logic word_last;

  assign word_last = !st.fill_ge32 || st.wcnt_max || (!st.more && st.fill_eq32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aisdec_pkg::ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aisdec_pkg::ST_COLLECT: begin
        if (in_valid && in_end_of_sentence) state_nxt = aisdec_pkg::ST_HDR;
      end
      aisdec_pkg::ST_HDR: begin
        if (st.out_free) begin
          state_nxt = st.hdr_last ? aisdec_pkg::ST_COLLECT : aisdec_pkg::ST_RD;
        end
      end
      aisdec_pkg::ST_RD:  state_nxt = aisdec_pkg::ST_APP;
      aisdec_pkg::ST_APP: state_nxt = aisdec_pkg::ST_EMIT;
      aisdec_pkg::ST_EMIT: begin
        if (st.fill_ge32 || !st.more) begin
          if (st.out_free && word_last) state_nxt = aisdec_pkg::ST_COLLECT;
        end else begin
          state_nxt = aisdec_pkg::ST_RD;
        end
      end
      default: state_nxt = aisdec_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      aisdec_pkg::ST_COLLECT: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      aisdec_pkg::ST_HDR: begin
        cmd.hdr_load = st.out_free;
        cmd.fin      = st.out_free && st.hdr_last;
      end
      aisdec_pkg::ST_RD:  cmd.rd  = 1'b1;
      aisdec_pkg::ST_APP: cmd.app = 1'b1;
      aisdec_pkg::ST_EMIT: begin
        if (st.fill_ge32 || !st.more) begin
          cmd.wload = st.out_free;
          cmd.wlast = word_last;
          cmd.fin   = st.out_free && word_last;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// ===== hdl/aisdec_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the AIS sentence decoder: symbol store, header capture, word packer, output register.
module aisdec_dp #(
  parameter int MAX_SYMBOLS = aisdec_pkg::MAX_SYMBOLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  aisdec_pkg::cmd_t  cmd,
  output aisdec_pkg::stat_t st,
  input  logic [7:0]        in_ch,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [5:0]        out_msg_type,
  output logic [1:0]        out_repeat_ind,
  output logic [29:0]       out_mmsi,
  output logic [1:0]        out_spare_bits,
  output logic [9:0]        out_area_code,
  output logic [5:0]        out_function_id,
  output logic [8:0]        out_total_bits,
  output logic [31:0]       out_data_word,
  output logic [3:0]        out_data_nibbles,
  output logic              out_last_result
);

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  logic [5:0] mem [MAX_SYMBOLS];
  logic [5:0] rdata_r;
  logic [5:0] hdr_sym_r [aisdec_pkg::HDR_SYMS];

  logic [2:0]                      comma_r;
  logic [CW-1:0]                   cnt_r;
  logic [CW-1:0]                   rd_idx_r;
  logic [aisdec_pkg::BUF_W-1:0]    buf_r;
  logic [aisdec_pkg::FILL_W-1:0]   fill_r;
  logic [aisdec_pkg::WCNT_W-1:0]   wcnt_r;

  logic                            out_valid_r;
  logic [1:0]                      kind_r;
  logic [5:0]                      msg_type_r;
  logic [1:0]                      repeat_r;
  logic [29:0]                     mmsi_r;
  logic [1:0]                      spare_r;
  logic [9:0]                      area_r;
  logic [5:0]                      func_r;
  logic [8:0]                      total_r;
  logic [31:0]                     word_r;
  logic [3:0]                      nibs_r;
  logic                            last_r;

  logic [5:0]                      sym;
  logic                            store_en;
  logic                            lt5;
  logic                            hdr_only;
  logic [59:0]                     hv;
  logic [15:0]                     tb;
  logic                            first;
  logic [2:0]                      app_n;
  logic [5:0]                      chunk;
  logic [2:0]                      sh;
  logic [31:0]                     word_full;
  logic [31:0]                     word_part;
  logic                            out_free;

  assign sym      = aisdec_pkg::dearmor(in_ch);
  assign store_en = cmd.accept && (in_ch != aisdec_pkg::CH_COMMA) &&
                    (comma_r == aisdec_pkg::PAYLOAD_FIELD) && (cnt_r < CW'(MAX_SYMBOLS));
  assign lt5      = comma_r < aisdec_pkg::PAYLOAD_FIELD;
  assign hdr_only = cnt_r < CW'(aisdec_pkg::HDR_SYMS);
  assign tb       = 16'(cnt_r) * 16'd6;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    for (int i = 0; i < aisdec_pkg::HDR_SYMS; i++) begin
      hv[59 - 6*i -: 6] = hdr_sym_r[i];
    end
  end

  assign first     = rd_idx_r == CW'(aisdec_pkg::FIRST_PAY_SYM);
  assign app_n     = (first && !cnt_r[0]) ? 3'd4 : 3'd6;
  assign chunk     = first ? {2'b00, rdata_r[3:0]} : rdata_r;
  assign sh        = 3'(fill_r - 6'd32);
  assign word_full = 32'(buf_r >> sh);
  assign word_part = 32'(buf_r << (6'd32 - fill_r));

  assign st.hdr_last  = lt5 || hdr_only;
  assign st.fill_ge32 = fill_r >= 6'd32;
  assign st.fill_eq32 = fill_r == 6'd32;
  assign st.more      = rd_idx_r < cnt_r;
  assign st.wcnt_max  = wcnt_r == aisdec_pkg::WCNT_W'(aisdec_pkg::MAX_WORDS - 1);
  assign st.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (store_en) mem[cnt_r[AW-1:0]] <= sym;
    if (cmd.rd) rdata_r <= mem[rd_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < aisdec_pkg::HDR_SYMS; i++) begin
      if (store_en && cnt_r == CW'(i)) hdr_sym_r[i] <= sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comma_r  <= '0;
      cnt_r    <= '0;
      rd_idx_r <= CW'(aisdec_pkg::FIRST_PAY_SYM);
      fill_r   <= '0;
      wcnt_r   <= '0;
    end else if (cmd.fin) begin
      comma_r  <= '0;
      cnt_r    <= '0;
      rd_idx_r <= CW'(aisdec_pkg::FIRST_PAY_SYM);
      fill_r   <= '0;
      wcnt_r   <= '0;
    end else begin
      if (cmd.accept && in_ch == aisdec_pkg::CH_COMMA && comma_r != aisdec_pkg::COMMA_SAT) begin
        comma_r <= comma_r + 3'd1;
      end
      if (store_en) cnt_r <= cnt_r + CW'(1);
      if (cmd.app) begin
        rd_idx_r <= rd_idx_r + CW'(1);
        fill_r   <= fill_r + 6'(app_n);
      end else if (cmd.wload && st.fill_ge32) begin
        fill_r   <= fill_r - 6'd32;
      end
      if (cmd.wload) wcnt_r <= wcnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.app) buf_r <= (buf_r << app_n) | aisdec_pkg::BUF_W'(chunk);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.hdr_load || cmd.wload) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_load) begin
      word_r <= '0;
      nibs_r <= '0;
      if (lt5) begin
        kind_r     <= aisdec_pkg::KIND_ERR;
        msg_type_r <= '0;
        repeat_r   <= '0;
        mmsi_r     <= '0;
        spare_r    <= '0;
        area_r     <= '0;
        func_r     <= '0;
        total_r    <= '0;
        last_r     <= 1'b1;
      end else begin
        kind_r     <= aisdec_pkg::KIND_HDR;
        msg_type_r <= (cnt_r >= CW'(aisdec_pkg::MIN_SYM_TYPE))   ? hv[59:54] : '0;
        repeat_r   <= (cnt_r >= CW'(aisdec_pkg::MIN_SYM_REPEAT)) ? hv[53:52] : '0;
        mmsi_r     <= (cnt_r >= CW'(aisdec_pkg::MIN_SYM_MMSI))   ? hv[51:22] : '0;
        spare_r    <= (cnt_r >= CW'(aisdec_pkg::MIN_SYM_SPARE))  ? hv[21:20] : '0;
        area_r     <= (cnt_r >= CW'(aisdec_pkg::MIN_SYM_AREA))   ? hv[19:10] : '0;
        func_r     <= (cnt_r >= CW'(aisdec_pkg::MIN_SYM_FUNC))   ? hv[9:4]   : '0;
        total_r    <= tb[8:0];
        last_r     <= hdr_only;
      end
    end else if (cmd.wload) begin
      kind_r     <= aisdec_pkg::KIND_WORD;
      msg_type_r <= '0;
      repeat_r   <= '0;
      mmsi_r     <= '0;
      spare_r    <= '0;
      area_r     <= '0;
      func_r     <= '0;
      total_r    <= '0;
      word_r     <= st.fill_ge32 ? word_full : word_part;
      nibs_r     <= st.fill_ge32 ? 4'd8 : fill_r[5:2];
      last_r     <= cmd.wlast;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_msg_type     = msg_type_r;
  assign out_repeat_ind   = repeat_r;
  assign out_mmsi         = mmsi_r;
  assign out_spare_bits   = spare_r;
  assign out_area_code    = area_r;
  assign out_function_id  = func_r;
  assign out_total_bits   = total_r;
  assign out_data_word    = word_r;
  assign out_data_nibbles = nibs_r;
  assign out_last_result  = last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 6'd37)
    else $error("packer fill out of range");

  a_word_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wload |=> nibs_r != 4'd0)
    else $error("payload word with no nibbles");

  a_word_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wload && st.wcnt_max) |-> cmd.wlast)
    else $error("word limit passed without last flag");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.hdr_load || cmd.wload) |-> out_free)
    else $error("output register overwritten while held");

endmodule

// ===== hdl/ais_type8_sentence_decoder_unit.sv =====
`timescale 1ns / 1ps
// AIS AIVDM sentence decoder top level.
// Input channel: one sentence byte per transfer (in_ch, in_end_of_sentence), taken at
// one per cycle while the sentence is being collected. Commas are counted; bytes of the
// sixth field are de-armored to 6-bit symbols and written to the symbol RAM.
// After the end-of-sentence byte the input stalls while results are produced.
// Result channel: an error result (fewer than five commas) or a header result, then up
// to eleven 32-bit payload words from bit 56, left-zero-padded to whole nibbles.
// out_valid for the header or error is set from the header state that follows the final
// byte transfer. Each payload word is built one symbol at a time, the symbol walk setting
// the pace: RAM read, packer append, emit check; the word loads in the emit check after
// the append that fills it, and a further emit check follows each full non-final word.
// The final result carries out_last_result; the input reopens as it is loaded, so the
// next sentence may stream in while that result is still held.
// A stalled receiver holds the output register and holds back the next result load.
// Reset (synchronous, active low) clears counters and control state; no clearing pass.
module ais_type8_sentence_decoder_unit #(
  parameter int MAX_SYMBOLS = aisdec_pkg::MAX_SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_end_of_sentence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [5:0]  out_msg_type,
  output logic [1:0]  out_repeat_ind,
  output logic [29:0] out_mmsi,
  output logic [1:0]  out_spare_bits,
  output logic [9:0]  out_area_code,
  output logic [5:0]  out_function_id,
  output logic [8:0]  out_total_bits,
  output logic [31:0] out_data_word,
  output logic [3:0]  out_data_nibbles,
  output logic        out_last_result
);

  aisdec_pkg::cmd_t  cmd;
  aisdec_pkg::stat_t st;

  aisdec_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_end_of_sentence (in_end_of_sentence),
    .in_stall           (in_stall),
    .st                 (st),
    .cmd                (cmd)
  );

  aisdec_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_msg_type     (out_msg_type),
    .out_repeat_ind   (out_repeat_ind),
    .out_mmsi         (out_mmsi),
    .out_spare_bits   (out_spare_bits),
    .out_area_code    (out_area_code),
    .out_function_id  (out_function_id),
    .out_total_bits   (out_total_bits),
    .out_data_word    (out_data_word),
    .out_data_nibbles (out_data_nibbles),
    .out_last_result  (out_last_result)
  );

endmodule

// ===== tb/sv/tb_ais_type8_sentence_decoder_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the AIS AIVDM sentence decoder unit.
module tb_ais_type8_sentence_decoder_unit;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SYM_CAP     = aisdec_pkg::MAX_SYMBOLS_DEF;
  localparam int HDR_BITS    = 56;
  localparam int NUM_DIR     = 14;
  localparam int MIN_BYTES   = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  msg_type;
    logic [1:0]  repeat_ind;
    logic [29:0] mmsi;
    logic [1:0]  spare_bits;
    logic [9:0]  area_code;
    logic [5:0]  function_id;
    logic [8:0]  total_bits;
    logic [31:0] data_word;
    logic [3:0]  data_nibbles;
    logic        last_result;
  } ais_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ch;
  logic        in_end_of_sentence;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [5:0]  out_msg_type;
  logic [1:0]  out_repeat_ind;
  logic [29:0] out_mmsi;
  logic [1:0]  out_spare_bits;
  logic [9:0]  out_area_code;
  logic [5:0]  out_function_id;
  logic [8:0]  out_total_bits;
  logic [31:0] out_data_word;
  logic [3:0]  out_data_nibbles;
  logic        out_last_result;

  ais_type8_sentence_decoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_ch             (in_ch),
    .in_end_of_sentence(in_end_of_sentence),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_msg_type      (out_msg_type),
    .out_repeat_ind    (out_repeat_ind),
    .out_mmsi          (out_mmsi),
    .out_spare_bits    (out_spare_bits),
    .out_area_code     (out_area_code),
    .out_function_id   (out_function_id),
    .out_total_bits    (out_total_bits),
    .out_data_word     (out_data_word),
    .out_data_nibbles  (out_data_nibbles),
    .out_last_result   (out_last_result)
  );

  // decoder model state
  logic [2:0]  comma_cnt;
  logic [5:0]  sym_mem [SYM_CAP];
  int          sym_cnt;

  ais_result_t decoded_q [$];
  ais_result_t want_res;
  ais_result_t typed_res;
  logic        use_typed;

  logic        tx_idle;
  logic        rx_idle;
  int          mismatches;
  int          results_seen;
  int          bytes_sent;
  int          sentences;
  int          cycles;

  logic [7:0]  sent_q [$];

  // '#' stands for byte 0x00 and '~' for byte 0xFF in these rows
  string dir_text [NUM_DIR] = '{
    "!AIVDM,1,1",
    "#",
    "!AIVDM,1,1,,A,,0*26",
    ",,,,,~",
    "!AIVDM,1,1,,A,0@AWaw/X{x#~,0*00",
    "!AIVDM,1,1,,B,w0w0w0w0w,0*00",
    "!AIVDM,1,1,,A,85MwpKw8ww,0*00",
    "!AIVDM,1,1,,A,wwwwwwwwwww",
    "!AIVDM,1,1,,B,0123456789:;<=>?@ABCDEFGHIJKLMNOPQRSTUVW{abcdefghijklmnopqrstuvw,0*00",
    "!AIVDM,1,1,,B,0123456789:;<=>?@ABCDEFGHIJKLMNOPQRSTUVW{abcdefghijklmnopqrstuvwXYZ[]_",
    "!AIVDM,1,1,,A,ABC,DEF,,,,x",
    ",,,,,w5,",
    ",,,,,",
    ",,,,~"
  };
  logic        dir_typed [NUM_DIR];
  ais_result_t dir_res   [NUM_DIR];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ais_type8_sentence_decoder_unit regression: fail");
      $finish;
    end
  end

  function automatic logic [5:0] to_symbol(input logic [7:0] c);
    if (c >= 8'd48 && c <= 8'd64) return 6'(c - 8'd48);
    if (c >= 8'd65 && c <= 8'd87) return 6'(c - 8'd65 + 8'd17);
    if (c >= 8'd97 && c <= 8'd119) return 6'(c - 8'd97 + 8'd41);
    return 6'd40;
  endfunction

  function automatic logic payload_bit(input int i);
    int s;
    s = i / 6;
    if (s >= sym_cnt) return 1'b0;
    return sym_mem[s][5 - (i % 6)];
  endfunction

  function automatic logic [29:0] header_field(input int start, input int len);
    logic [29:0] v;
    v = '0;
    if (start + len > 6 * sym_cnt) return '0;
    for (int i = 0; i < len; i++) v = {v[28:0], payload_bit(start + i)};
    return v;
  endfunction

  function automatic ais_result_t glance(input logic [1:0] kind, input logic [5:0] msg,
                                         input logic [8:0] total);
    ais_result_t r;
    r = '0;
    r.kind = kind;
    r.msg_type = msg;
    r.total_bits = total;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic void expect_result(input ais_result_t r);
    decoded_q = {decoded_q, r};
  endfunction

  // advance the decoder model by one accepted byte
  function automatic void decode_byte(input logic [7:0] c, input logic eos);
    ais_result_t res_q [$];
    ais_result_t r;
    int total, plen, pad, nibs, words, idx, j;
    logic [3:0] nib;
    if (c == aisdec_pkg::CH_COMMA) begin
      if (comma_cnt != aisdec_pkg::COMMA_SAT) comma_cnt = comma_cnt + 3'd1;
    end else if (comma_cnt == aisdec_pkg::PAYLOAD_FIELD && sym_cnt < SYM_CAP) begin
      sym_mem[sym_cnt] = to_symbol(c);
      sym_cnt++;
    end
    if (!eos) return;
    sentences++;
    if (comma_cnt < aisdec_pkg::PAYLOAD_FIELD) begin
      res_q = {res_q, glance(aisdec_pkg::KIND_ERR, '0, '0)};
    end else begin
      total = 6 * sym_cnt;
      r = '0;
      r.kind        = aisdec_pkg::KIND_HDR;
      r.msg_type    = 6'(header_field(0, 6));
      r.repeat_ind  = 2'(header_field(6, 2));
      r.mmsi        = header_field(8, 30);
      r.spare_bits  = 2'(header_field(38, 2));
      r.area_code   = 10'(header_field(40, 10));
      r.function_id = 6'(header_field(50, 6));
      r.total_bits  = 9'(total);
      res_q = {res_q, r};
      plen  = total > HDR_BITS ? total - HDR_BITS : 0;
      pad   = (4 - (plen % 4)) % 4;
      nibs  = (plen + pad) / 4;
      words = (nibs + 7) / 8;
      if (words > aisdec_pkg::MAX_WORDS) words = aisdec_pkg::MAX_WORDS;
      for (int w = 0; w < words; w++) begin
        r = '0;
        r.kind = aisdec_pkg::KIND_WORD;
        for (int k = 0; k < 8; k++) begin
          idx = w * 8 + k;
          if (idx < nibs) begin
            nib = '0;
            for (int b = 0; b < 4; b++) begin
              j = idx * 4 + b;
              nib = {nib[2:0], (j >= pad) ? payload_bit(HDR_BITS + j - pad) : 1'b0};
            end
            r.data_word = r.data_word | (32'(nib) << (28 - 4 * k));
            r.data_nibbles = r.data_nibbles + 4'd1;
          end
        end
        res_q = {res_q, r};
      end
      res_q[res_q.size() - 1].last_result = 1'b1;
    end
    if (use_typed) expect_result(typed_res);
    else foreach (res_q[i]) expect_result(res_q[i]);
    comma_cnt = '0;
    sym_cnt = 0;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected: kind %0d", out_kind);
        mismatches++;
      end else begin
        want_res = decoded_q.pop_front();
        results_seen++;
        check_field("kind",         32'(want_res.kind),         32'(out_kind));
        check_field("msg_type",     32'(want_res.msg_type),     32'(out_msg_type));
        check_field("repeat_ind",   32'(want_res.repeat_ind),   32'(out_repeat_ind));
        check_field("mmsi",         32'(want_res.mmsi),         32'(out_mmsi));
        check_field("spare_bits",   32'(want_res.spare_bits),   32'(out_spare_bits));
        check_field("area_code",    32'(want_res.area_code),    32'(out_area_code));
        check_field("function_id",  32'(want_res.function_id),  32'(out_function_id));
        check_field("total_bits",   32'(want_res.total_bits),   32'(out_total_bits));
        check_field("data_word",    want_res.data_word,         out_data_word);
        check_field("data_nibbles", 32'(want_res.data_nibbles), 32'(out_data_nibbles));
        check_field("last_result",  32'(want_res.last_result),  32'(out_last_result));
      end
    end
  end

  // result side: random stall before each transfer while rx_idle is set
  initial begin : rx_side
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = rx_idle ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic eos);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_ch = c;
    in_end_of_sentence = eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(c, eos);
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_sentence();
    for (int i = 0; i < sent_q.size(); i++) send_byte(sent_q[i], i == sent_q.size() - 1);
  endtask

  task automatic wait_drained();
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] armored_char();
    int v;
    v = $urandom_range(0, 63);
    if (v <= 16) return 8'(48 + v);
    if (v <= 39) return 8'(65 + v - 17);
    if (v >= 41) return 8'(97 + v - 41);
    v = $urandom_range(0, 255);
    return (v == aisdec_pkg::CH_COMMA) ? 8'd0 : 8'(v);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    sent_q = {sent_q, b};
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void build_random_sentence();
    int pick, n;
    sent_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      push_text($urandom_range(0, 1) ? "!AIVDM,1,1,," : "!AIVDO,2,1,3,");
      put_byte($urandom_range(0, 1) ? "A" : "B");
      put_byte(aisdec_pkg::CH_COMMA);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 20);
      repeat (n) put_byte(armored_char());
      if ($urandom_range(0, 3) != 0) begin
        push_text(",0*");
        repeat (2) put_byte(8'($urandom_range(48, 70)));
      end
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) put_byte(aisdec_pkg::CH_COMMA);
      if (sent_q.size() == 0) put_byte(aisdec_pkg::CH_COMMA);
    end else if (pick < 85) begin
      n = $urandom_range(0, 4);
      repeat (n) begin
        repeat ($urandom_range(0, 5)) put_byte(armored_char());
        put_byte(aisdec_pkg::CH_COMMA);
      end
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255) & 8'hDF));
    end else begin
      repeat ($urandom_range(1, 30))
        put_byte(($urandom_range(0, 4) == 0) ? aisdec_pkg::CH_COMMA : 8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin : stimulus
    logic [7:0] c;
    int rnd_idx;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ch = '0;
    in_end_of_sentence = 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    use_typed = 1'b0;
    typed_res = '0;
    comma_cnt = '0;
    sym_cnt = 0;
    mismatches = 0;
    results_seen = 0;
    bytes_sent = 0;
    sentences = 0;
    cycles = 0;
    foreach (dir_typed[i]) begin
      dir_typed[i] = 1'b0;
      dir_res[i] = '0;
    end
    dir_typed[0]  = 1'b1; dir_res[0]  = glance(aisdec_pkg::KIND_ERR, '0, '0);
    dir_typed[1]  = 1'b1; dir_res[1]  = glance(aisdec_pkg::KIND_ERR, '0, '0);
    dir_typed[2]  = 1'b1; dir_res[2]  = glance(aisdec_pkg::KIND_HDR, '0, '0);
    dir_typed[3]  = 1'b1; dir_res[3]  = glance(aisdec_pkg::KIND_HDR, 6'd40, 9'd6);
    dir_typed[12] = 1'b1; dir_res[12] = glance(aisdec_pkg::KIND_HDR, '0, '0);
    dir_typed[13] = 1'b1; dir_res[13] = glance(aisdec_pkg::KIND_ERR, '0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NUM_DIR; r++) begin
      sent_q.delete();
      for (int i = 0; i < dir_text[r].len(); i++) begin
        c = dir_text[r][i];
        if (c == "#") c = 8'h00;
        else if (c == "~") c = 8'hFF;
        put_byte(c);
      end
      tx_idle = (r % 3 != 0);
      rx_idle = (r % 4 != 1);
      use_typed = dir_typed[r];
      typed_res = dir_res[r];
      send_sentence();
      use_typed = 1'b0;
    end
    wait_drained();

    rnd_idx = 0;
    while (bytes_sent < MIN_BYTES) begin
      build_random_sentence();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      send_sentence();
      rnd_idx++;
      if (rnd_idx == 1) wait_drained();
    end
    in_valid = 1'b0;
    in_end_of_sentence = 1'b0;

    wait_drained();
    repeat (60) @(posedge clk);

    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      mismatches++;
    end
    $display("covered %0d sentences (%0d bytes) with %0d results checked, %0d mismatches",
             sentences, bytes_sent, results_seen, mismatches);
    $display("includes error, empty-field, short, full-store and saturated-comma sentences");
    if (mismatches == 0) begin
      $display("ais_type8_sentence_decoder_unit regression: pass");
    end else begin
      $display("ais_type8_sentence_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
